/* rtl/smh_pkg.sv */
package smh_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W    = 8;
    localparam int MAG_W    = 21;
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int WIDTH_W  = 12;
    localparam int HEIGHT_W = 13;
    localparam int THR_W    = 21;
    localparam int CLASS_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;
    localparam int OUT_DATA_W = 48;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESH  = 2'd3;

    // Reset values of the registers.
    localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 12'd640;
    localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 13'd480;
    localparam logic [THR_W-1:0]    RESET_LOW    = 21'd14400;
    localparam logic [THR_W-1:0]    RESET_HIGH   = 21'd57600;

    // Edge class codes.
    localparam logic [CLASS_W-1:0] CLASS_NONE   = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_WEAK   = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_STRONG = 2'd2;

    // Position of a pixel and what it is good for, carried down the pipe.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             mag_ok;
        logic             cls_ok;
        logic             last;
    } smh_pos_t;

endpackage

/* rtl/smh_gradient.sv */
module smh_gradient (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [smh_pkg::PIX_W-1:0] in_pixel,
    input  smh_pkg::smh_pos_t       in_pos,
    output logic                    mag_valid,
    output logic [smh_pkg::MAG_W-1:0] mag_value,
    output smh_pkg::smh_pos_t       mag_pos
);
    import smh_pkg::*;

    // Line store: upper byte holds row r-2, lower byte row r-1.
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] mem_rd_reg;
    logic               fwd_reg;
    logic [2*PIX_W-1:0] fwd_data_reg;

    logic               s1_valid_reg;
    logic [PIX_W-1:0]   s1_pixel_reg;
    smh_pos_t           s1_pos_reg;

    logic [PIX_W-1:0]   win_a_reg [3];
    logic [PIX_W-1:0]   win_b_reg [3];

    logic               s2_valid_reg;
    smh_pos_t           s2_pos_reg;
    logic signed [10:0] dx_reg;
    logic signed [10:0] dy_reg;

    logic [2*PIX_W-1:0] line_word;
    logic [2*PIX_W-1:0] wr_word;
    logic [PIX_W-1:0]   new_col [3];
    logic [9:0]         sum_left;
    logic [9:0]         sum_right;
    logic [9:0]         sum_top;
    logic [9:0]         sum_bot;
    logic signed [10:0] dx_next;
    logic signed [10:0] dy_next;
    logic signed [21:0] dx_sq;
    logic signed [21:0] dy_sq;
    logic               wr_en;
    logic               rd_en;

    assign line_word  = fwd_reg ? fwd_data_reg : mem_rd_reg;
    assign new_col[0] = line_word[2*PIX_W-1:PIX_W];
    assign new_col[1] = line_word[PIX_W-1:0];
    assign new_col[2] = s1_pixel_reg;
    assign wr_word    = {line_word[PIX_W-1:0], s1_pixel_reg};
    assign wr_en      = en && s1_valid_reg;
    assign rd_en      = en && in_valid;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[s1_pos_reg.col] <= wr_word;
        end
        if (rd_en)
        begin
            mem_rd_reg   <= line_mem[in_pos.col];
            fwd_reg      <= wr_en && (in_pos.col == s1_pos_reg.col);
            fwd_data_reg <= wr_word;
        end
    end

    // Window columns: a = left, b = middle, new_col = right.
    always_comb
    begin
        sum_left  = {2'b00, win_a_reg[0]} + {1'b0, win_a_reg[1], 1'b0} + {2'b00, win_a_reg[2]};
        sum_right = {2'b00, new_col[0]} + {1'b0, new_col[1], 1'b0} + {2'b00, new_col[2]};
        sum_top   = {2'b00, win_a_reg[0]} + {1'b0, win_b_reg[0], 1'b0} + {2'b00, new_col[0]};
        sum_bot   = {2'b00, win_a_reg[2]} + {1'b0, win_b_reg[2], 1'b0} + {2'b00, new_col[2]};
        dx_next   = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
        dy_next   = $signed({1'b0, sum_bot}) - $signed({1'b0, sum_top});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                win_a_reg[k] <= '0;
                win_b_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_a_reg[k] <= win_b_reg[k];
                    win_b_reg[k] <= new_col[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_pixel_reg <= in_pixel;
            s1_pos_reg   <= in_pos;
            s2_pos_reg   <= s1_pos_reg;
            dx_reg       <= dx_next;
            dy_reg       <= dy_next;
        end
    end

    assign dx_sq     = dx_reg * dx_reg;
    assign dy_sq     = dy_reg * dy_reg;
    assign mag_valid = s2_valid_reg;
    assign mag_pos   = s2_pos_reg;
    assign mag_value = s2_pos_reg.mag_ok ? (dx_sq[MAG_W-1:0] + dy_sq[MAG_W-1:0]) : '0;

endmodule

/* rtl/smh_classify.sv */
module smh_classify (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [smh_pkg::MAG_W-1:0]   in_mag,
    input  smh_pkg::smh_pos_t           in_pos,
    input  logic [smh_pkg::THR_W-1:0]   low_thresh,
    input  logic [smh_pkg::THR_W-1:0]   high_thresh,
    output logic                        out_valid,
    output logic [smh_pkg::MAG_W-1:0]   out_mag,
    output logic [smh_pkg::CLASS_W-1:0] out_class,
    output logic [smh_pkg::ROW_W-1:0]   out_row,
    output logic [smh_pkg::COL_W-1:0]   out_col,
    output logic                        out_last
);
    import smh_pkg::*;

    // Line store: upper half holds row r-2, lower half row r-1.
    logic [2*MAG_W-1:0] line_mem [MAX_WIDTH];
    logic [2*MAG_W-1:0] mem_rd_reg;
    logic               fwd_reg;
    logic [2*MAG_W-1:0] fwd_data_reg;

    logic               s3_valid_reg;
    logic [MAG_W-1:0]   s3_mag_reg;
    smh_pos_t           s3_pos_reg;

    logic [MAG_W-1:0]   win_a_reg [3];
    logic [MAG_W-1:0]   win_b_reg [3];

    logic               out_valid_reg;
    logic [MAG_W-1:0]   out_mag_reg;
    logic [CLASS_W-1:0] out_class_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic               out_last_reg;

    logic [2*MAG_W-1:0] line_word;
    logic [2*MAG_W-1:0] wr_word;
    logic [MAG_W-1:0]   new_col [3];
    logic [MAG_W-1:0]   centre;
    logic               strong_nb;
    logic [CLASS_W-1:0] class_next;
    logic [MAG_W-1:0]   mag_next;
    logic               wr_en;
    logic               rd_en;

    assign line_word  = fwd_reg ? fwd_data_reg : mem_rd_reg;
    assign new_col[0] = line_word[2*MAG_W-1:MAG_W];
    assign new_col[1] = line_word[MAG_W-1:0];
    assign new_col[2] = s3_mag_reg;
    assign wr_word    = {line_word[MAG_W-1:0], s3_mag_reg};
    assign wr_en      = en && s3_valid_reg;
    assign rd_en      = en && in_valid;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[s3_pos_reg.col] <= wr_word;
        end
        if (rd_en)
        begin
            mem_rd_reg   <= line_mem[in_pos.col];
            fwd_reg      <= wr_en && (in_pos.col == s3_pos_reg.col);
            fwd_data_reg <= wr_word;
        end
    end

    // After the shift the centre is the middle of column b.
    always_comb
    begin
        centre    = win_b_reg[1];
        strong_nb = (win_a_reg[0] >= high_thresh) || (win_a_reg[1] >= high_thresh)
                 || (win_a_reg[2] >= high_thresh) || (win_b_reg[0] >= high_thresh)
                 || (win_b_reg[2] >= high_thresh) || (new_col[0] >= high_thresh)
                 || (new_col[1] >= high_thresh) || (new_col[2] >= high_thresh);
        class_next = CLASS_NONE;
        mag_next   = '0;
        if (centre >= high_thresh)
        begin
            class_next = CLASS_STRONG;
            mag_next   = centre;
        end
        else if ((centre >= low_thresh) && strong_nb)
        begin
            class_next = CLASS_WEAK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                win_a_reg[k] <= '0;
                win_b_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            s3_valid_reg  <= in_valid;
            out_valid_reg <= s3_valid_reg && s3_pos_reg.cls_ok;
            if (s3_valid_reg)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_a_reg[k] <= win_b_reg[k];
                    win_b_reg[k] <= new_col[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_mag_reg    <= in_mag;
            s3_pos_reg    <= in_pos;
            out_mag_reg   <= mag_next;
            out_class_reg <= class_next;
            out_row_reg   <= s3_pos_reg.row - ROW_W'(2);
            out_col_reg   <= s3_pos_reg.col - COL_W'(2);
            out_last_reg  <= s3_pos_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_mag   = out_mag_reg;
    assign out_class = out_class_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_last  = out_last_reg;

endmodule

/* rtl/sobel_magnitude_hysteresis_top.sv */
// Path: the pixel beat that completes a window is taken into the s1 registers, then dx/dy,
// then the classify input register (s3), then the output register that drives the master side.
// Throughput: one pixel per clock; each pipeline stage, both line-store ports and the
// output register move every cycle unless the output beat is held by m_axis_tready low.
// Reset (rst_n low, asynchronous): counters, windows, valid flags and configuration
// registers return to their defaults; the line stores are not cleared and need no sweep.
module sobel_magnitude_hysteresis_top (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port.
    input  logic                             cfg_wr_en,
    input  logic [smh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [smh_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Pixel stream in.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [7:0] pixel
    input  logic [0:0]                       s_axis_tuser,  // [0] frame_start
    // Classified pixel stream out.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [20:0] magnitude_sq, [22:21] edge_class, [34:23] out_row, [45:35] out_col,
    // [47:46] zero
    output logic [smh_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tlast   // frame_last
);
    import smh_pkg::*;

    logic [WIDTH_W-1:0]  cfg_width_reg;
    logic [HEIGHT_W-1:0] cfg_height_reg;
    logic [THR_W-1:0]    low_thresh_reg;
    logic [THR_W-1:0]    high_thresh_reg;

    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;

    logic [WIDTH_W-1:0]  eff_width;
    logic [HEIGHT_W-1:0] eff_height;
    logic [ROW_W-1:0]    cur_row;
    logic [COL_W-1:0]    cur_col;
    logic [HEIGHT_W-1:0] row_plus;
    logic [WIDTH_W-1:0]  col_plus;
    logic                in_bounds;
    smh_pos_t            cur_pos;

    logic                en;
    logic                accept;

    logic                mag_valid;
    logic [MAG_W-1:0]    mag_value;
    smh_pos_t            mag_pos;

    logic                res_valid;
    logic [MAG_W-1:0]    res_mag;
    logic [CLASS_W-1:0]  res_class;
    logic [ROW_W-1:0]    res_row;
    logic [COL_W-1:0]    res_col;
    logic                res_last;

    // The whole pipe moves together; it only waits while a finished beat is held.
    assign en            = !res_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg   <= RESET_WIDTH;
            cfg_height_reg  <= RESET_HEIGHT;
            low_thresh_reg  <= RESET_LOW;
            high_thresh_reg <= RESET_HIGH;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_width_reg   <= cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: cfg_height_reg  <= cfg_data[HEIGHT_W-1:0];
                REG_LOW_THRESH:   low_thresh_reg  <= cfg_data[THR_W-1:0];
                REG_HIGH_THRESH:  high_thresh_reg <= cfg_data[THR_W-1:0];
                default:          ;
            endcase
        end
    end

    // Oversized geometry clamps to MAX_WIDTH and MAX_HEIGHT, and zero acts as one.
    always_comb
    begin
        if (cfg_width_reg > WIDTH_W'(MAX_WIDTH))
            eff_width = WIDTH_W'(MAX_WIDTH);
        else if (cfg_width_reg == '0)
            eff_width = WIDTH_W'(1);
        else
            eff_width = cfg_width_reg;

        if (cfg_height_reg > HEIGHT_W'(MAX_HEIGHT))
            eff_height = HEIGHT_W'(MAX_HEIGHT);
        else if (cfg_height_reg == '0)
            eff_height = HEIGHT_W'(1);
        else
            eff_height = cfg_height_reg;
    end

    // A frame start forces the position of this beat to the top left corner.
    always_comb
    begin
        cur_row   = s_axis_tuser[0] ? '0 : row_reg;
        cur_col   = s_axis_tuser[0] ? '0 : col_reg;
        row_plus  = {1'b0, cur_row} + HEIGHT_W'(1);
        col_plus  = {1'b0, cur_col} + WIDTH_W'(1);
        in_bounds = ({1'b0, cur_row} < eff_height) && ({1'b0, cur_col} < eff_width);

        cur_pos.row    = cur_row;
        cur_pos.col    = cur_col;
        cur_pos.mag_ok = in_bounds && (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
        cur_pos.cls_ok = in_bounds && (cur_row >= ROW_W'(4)) && (cur_col >= COL_W'(4));
        cur_pos.last   = (row_plus == eff_height) && (col_plus == eff_width);

        if (col_plus >= eff_width)
        begin
            col_next = '0;
            row_next = (row_plus >= eff_height) ? '0 : row_plus[ROW_W-1:0];
        end
        else
        begin
            col_next = col_plus[COL_W-1:0];
            row_next = cur_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // Pixel line store, Sobel window and squared magnitude.
    smh_gradient u_gradient (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (accept),
        .in_pixel  (s_axis_tdata),
        .in_pos    (cur_pos),
        .mag_valid (mag_valid),
        .mag_value (mag_value),
        .mag_pos   (mag_pos)
    );

    // Magnitude line store, neighbour window, thresholds and the output register.
    smh_classify u_classify (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (mag_valid),
        .in_mag      (mag_value),
        .in_pos      (mag_pos),
        .low_thresh  (low_thresh_reg),
        .high_thresh (high_thresh_reg),
        .out_valid   (res_valid),
        .out_mag     (res_mag),
        .out_class   (res_class),
        .out_row     (res_row),
        .out_col     (res_col),
        .out_last    (res_last)
    );

    assign m_axis_tvalid = res_valid;
    assign m_axis_tdata  = {2'b00, res_col, res_row, res_class, res_mag};
    assign m_axis_tlast  = res_last;

endmodule

/* rtl/smh_checker.sv */
module smh_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [smh_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           m_axis_tlast
);
    import smh_pkg::*;

    // A held output beat keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("held output beat changed");

    // Input is only held back while a finished beat waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

    // Only the three defined class codes appear.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[22:21] == CLASS_NONE)
            || (m_axis_tdata[22:21] == CLASS_WEAK) || (m_axis_tdata[22:21] == CLASS_STRONG))
    else $error("undefined edge class");

    // The magnitude is reported for strong edges only.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[22:21] != CLASS_STRONG) |-> (m_axis_tdata[20:0] == '0))
    else $error("magnitude on a non-strong pixel");

endmodule

bind sobel_magnitude_hysteresis_top smh_checker u_checker (.*);
